// ===== src/hrug_pkg.sv =====
// ----------------------------------------------------------------------------
// hrug_pkg
// Shared constants, types and helpers for the HIMM ray update generator.
// ----------------------------------------------------------------------------
package hrug_pkg;

  localparam int STORE_DEPTH     = 4096;
  localparam int STORE_AW        = 12;
  localparam int CELL_W          = 8;
  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int MAX_STEPS_DEF   = 63;
  localparam int RC_W            = 10;   // grid row/column index, sides up to 1024
  localparam int FULL_AW         = 20;   // row*width+column before the store check
  localparam int CORDIC_ITERS    = 24;
  localparam int DIV_W           = 33;   // dividend / quotient
  localparam int DVS_W           = 31;   // divisor / remainder
  localparam int AMT_W           = 13;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [65:0] HALF_Q30    = 66'sd536870912;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RAY   = 1'b1;

  localparam logic [1:0] CFG_INC_AMT = 2'd0;
  localparam logic [1:0] CFG_DEC_AMT = 2'd1;
  localparam logic [1:0] CFG_MAX_RD  = 2'd2;
  localparam logic [1:0] CFG_EDGE    = 2'd3;

  typedef struct packed {
    logic        start;
    logic [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] cos;
    logic signed [31:0] sin;
  } cordic_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/hrug_grid_ram.sv =====
// ----------------------------------------------------------------------------
// hrug_grid_ram
// Occupancy grid store, one write and one registered read port, with a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module hrug_grid_ram (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [hrug_pkg::STORE_AW-1:0]   wr_addr_i,
  input  logic [hrug_pkg::CELL_W-1:0]     wr_data_i,
  input  logic [hrug_pkg::STORE_AW-1:0]   rd_addr_i,
  output logic [hrug_pkg::CELL_W-1:0]     rd_data_o,
  output logic                            clear_busy_o
);

  logic [hrug_pkg::CELL_W-1:0]   mem [hrug_pkg::STORE_DEPTH];
  logic [hrug_pkg::STORE_AW-1:0] clr_addr_q;
  logic                          clr_busy_q;
  logic [hrug_pkg::CELL_W-1:0]   rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o    = rd_data_q;
  assign clear_busy_o = clr_busy_q;

endmodule

// ===== src/hrug_cordic.sv =====
// ----------------------------------------------------------------------------
// hrug_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving
// cosine and sine in Q2.30 of a 16-bit binary angle.
// ----------------------------------------------------------------------------
module hrug_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hrug_pkg::cordic_req_t req_i,
  output hrug_pkg::cordic_rsp_t rsp_o
);

  logic signed [31:0] x_q, y_q, z_q;
  logic signed [31:0] xs, ys, at;
  logic [4:0]         it_q;
  logic [1:0]         quad_q;
  logic               busy_q, done_q;

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;
  assign at = hrug_pkg::atan_lut(it_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        it_q <= it_q + 1'b1;
        if (it_q == 5'(hrug_pkg::CORDIC_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= hrug_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= $signed({2'b00, req_i.angle[13:0], 16'h0000});
      quad_q <= req_i.angle[15:14];
    end else if (busy_q) begin
      if (!z_q[31]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    rsp_o.busy = busy_q;
    rsp_o.done = done_q;
    case (quad_q)
      2'd0: begin
        rsp_o.cos = x_q;
        rsp_o.sin = y_q;
      end
      2'd1: begin
        rsp_o.cos = -y_q;
        rsp_o.sin = x_q;
      end
      2'd2: begin
        rsp_o.cos = -x_q;
        rsp_o.sin = -y_q;
      end
      default: begin
        rsp_o.cos = y_q;
        rsp_o.sin = -x_q;
      end
    endcase
  end

endmodule

// ===== src/hrug_div.sv =====
// ----------------------------------------------------------------------------
// hrug_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrug_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hrug_pkg::div_req_t req_i,
  output hrug_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(hrug_pkg::DIV_W + 1);

  logic [hrug_pkg::DIV_W-1:0] quot_q;
  logic [hrug_pkg::DVS_W-1:0] rem_q, dvs_q;
  logic [hrug_pkg::DVS_W:0]   trial;
  logic                       fits;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q, done_q;

  assign trial = {rem_q, quot_q[hrug_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(hrug_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      dvs_q  <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[hrug_pkg::DIV_W-2:0], fits};
      rem_q  <= fits ? hrug_pkg::DVS_W'(trial - {1'b0, dvs_q})
                     : trial[hrug_pkg::DVS_W-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== src/himm_ray_update_generator_unit.sv =====
// Sequence: a grid write is stored as it is accepted; a ray runs to its first
// result through two 24-step CORDIC passes, six shared multiplies, up to five
// 33-bit divides and nine grid reads, then gives one result per cycle if taken.
// One item is handled at a time; input is ready only in the idle state.
// Reset: registers return to their defaults and the grid is swept to zero,
// one cell per cycle over all 4096 cells, with input not ready meanwhile.
// ----------------------------------------------------------------------------
// himm_ray_update_generator_unit
// Occupancy grid ray update generator: obstacle increment and DDA decrements.
// ----------------------------------------------------------------------------
module himm_ray_update_generator_unit #(
  parameter int GRID_WIDTH  = hrug_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = hrug_pkg::GRID_HEIGHT_DEF,
  parameter int MAX_STEPS   = hrug_pkg::MAX_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // cell_index, cell_value, robot_x, robot_y, robot_heading, mount_x,
  // mount_y, mount_angle, range_reading
  input  logic [215:0] s_axis_tdata_i,
  // command
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // update_x, update_y, update_amount
  output logic [79:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  input  logic         cfg_wr_en_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [30:0]  cfg_wdata_i
);

  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int DIV_W_T = hrug_pkg::DIV_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_COR1, S_COR2, S_MUL, S_POSE, S_OBS, S_GEO, S_DIST,
    S_DIVN, S_DIVSX, S_DIVSY, S_DIVCX, S_DIVCY, S_READ, S_EMIT
  } state_e;

  state_e state_q;

  logic [7:0]  inc_amt_q, dec_amt_q;
  logic [30:0] max_rd_q, edge_q, edge_eff;

  logic signed [31:0] rx_q, ry_q, mx_q, my_q;
  logic [15:0]        head_q, mang_q;
  logic [30:0]        rng_q;
  logic signed [31:0] cr_q, sr_q, cs_q, ss_q;
  logic [2:0]         mul_idx_q;
  logic signed [63:0] prod_q;
  logic signed [65:0] acc_a_q, acc_b_q;
  logic signed [63:0] acc_c_q, acc_d_q;
  logic signed [31:0] sx_q, sy_q, ox_q, oy_q;
  logic signed [32:0] dx_q, dy_q;
  logic [32:0]        adx, ady, big, aox, aoy;
  logic               inc_q, emit_inc_q;
  logic [STEP_W-1:0]  steps_q, step_i_q;
  logic [31:0]        stx_q, sty_q, px_q, py_q;
  logic signed [33:0] cx_q, cy_q;
  logic [3:0]         rd_cnt_q;
  logic               rd_vld_q, rd_ctr_q;
  logic [12:0]        sum_q;
  logic               cor_go_q, div_go_q;

  logic                   m_vld_q, m_last_q;
  logic signed [31:0]     m_x_q, m_y_q;
  logic [12:0]            m_amt_q;
  logic                   out_free, out_load, dec_last;

  hrug_pkg::cordic_req_t cor_req;
  hrug_pkg::cordic_rsp_t cor_rsp;
  hrug_pkg::div_req_t    div_req;
  hrug_pkg::div_rsp_t    div_rsp;

  logic                          in_xfer, ram_we, clear_busy;
  logic [hrug_pkg::STORE_AW-1:0] ram_raddr;
  logic [hrug_pkg::CELL_W-1:0]   ram_rdata;

  logic signed [31:0] op_a, op_b;
  logic signed [65:0] rnd_a, rnd_b, rnd_c, rnd_d;
  logic signed [31:0] sx_d, sy_d, ox_d, oy_d;
  logic signed [1:0]  dp, dq;
  logic signed [33:0] col, row;
  logic [hrug_pkg::FULL_AW-1:0] addr_full;
  logic               cell_ok;
  logic [DIV_W_T-1:0] n_quot_sat;
  logic signed [33:0] fq;
  logic [STEP_W-1:0]  n_d;

  assign edge_eff = (edge_q == '0) ? 31'd1 : edge_q;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign ram_we   = in_xfer && (s_axis_tuser_i == hrug_pkg::CMD_WRITE);
  assign out_free = !m_vld_q || m_axis_tready_i;
  assign out_load = (state_q == S_EMIT) && out_free;
  assign dec_last = (step_i_q == steps_q - 1'b1);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_amt_q <= 8'd3;
      dec_amt_q <= 8'd1;
      max_rd_q  <= 31'd327680;
      edge_q    <= 31'd6554;
    end else if (cfg_wr_en_i) begin
      case (cfg_addr_i)
        hrug_pkg::CFG_INC_AMT: inc_amt_q <= cfg_wdata_i[7:0];
        hrug_pkg::CFG_DEC_AMT: dec_amt_q <= cfg_wdata_i[7:0];
        hrug_pkg::CFG_MAX_RD:  max_rd_q  <= cfg_wdata_i;
        hrug_pkg::CFG_EDGE:    edge_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hrug_grid_ram u_ram (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (ram_we),
    .wr_addr_i    (s_axis_tdata_i[11:0]),
    .wr_data_i    (s_axis_tdata_i[19:12]),
    .rd_addr_i    (ram_raddr),
    .rd_data_o    (ram_rdata),
    .clear_busy_o (clear_busy)
  );

  hrug_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  hrug_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cor_req.start = cor_go_q;
  assign cor_req.angle = (state_q == S_COR1) ? head_q : 16'(head_q + mang_q);

  // datapath
  always_comb begin
    case (mul_idx_q)
      3'd0: begin op_a = mx_q; op_b = cr_q; end
      3'd1: begin op_a = my_q; op_b = sr_q; end
      3'd2: begin op_a = mx_q; op_b = sr_q; end
      3'd3: begin op_a = my_q; op_b = cr_q; end
      3'd4: begin op_a = $signed({1'b0, rng_q}); op_b = cs_q; end
      default: begin op_a = $signed({1'b0, rng_q}); op_b = ss_q; end
    endcase

    rnd_a = (acc_a_q + hrug_pkg::HALF_Q30) >>> 30;
    rnd_b = (acc_b_q + hrug_pkg::HALF_Q30) >>> 30;
    rnd_c = (66'(acc_c_q) + hrug_pkg::HALF_Q30) >>> 30;
    rnd_d = (66'(acc_d_q) + hrug_pkg::HALF_Q30) >>> 30;
    sx_d  = hrug_pkg::sat32(37'(rx_q) + 37'(rnd_a));
    sy_d  = hrug_pkg::sat32(37'(ry_q) + 37'(rnd_b));
    ox_d  = hrug_pkg::sat32(37'(sx_q) + 37'(rnd_c));
    oy_d  = hrug_pkg::sat32(37'(sy_q) + 37'(rnd_d));

    adx = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
    ady = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
    big = (adx > ady) ? adx : ady;
    aox = ox_q[31] ? 33'(-(33'(ox_q))) : 33'(ox_q);
    aoy = oy_q[31] ? 33'(-(33'(oy_q))) : 33'(oy_q);

    n_quot_sat = div_rsp.quot;
    n_d = (n_quot_sat > DIV_W_T'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                             : n_quot_sat[STEP_W-1:0];
    // floored quotient of a signed coordinate
    fq = $signed({1'b0, div_rsp.quot});
    if (state_q == S_DIVCX ? ox_q[31] : oy_q[31]) begin
      fq = -(fq + 34'(div_rsp.rem != '0));
    end

    case (rd_cnt_q)
      4'd0: begin dp = -2'sd1; dq = -2'sd1; end
      4'd1: begin dp =  2'sd0; dq = -2'sd1; end
      4'd2: begin dp =  2'sd1; dq = -2'sd1; end
      4'd3: begin dp = -2'sd1; dq =  2'sd0; end
      4'd4: begin dp =  2'sd0; dq =  2'sd0; end
      4'd5: begin dp =  2'sd1; dq =  2'sd0; end
      4'd6: begin dp = -2'sd1; dq =  2'sd1; end
      4'd7: begin dp =  2'sd0; dq =  2'sd1; end
      default: begin dp = 2'sd1; dq = 2'sd1; end
    endcase
    col = cx_q + 34'(dp);
    row = cy_q + 34'(dq);
    addr_full = hrug_pkg::FULL_AW'(row[hrug_pkg::RC_W-1:0])
                * hrug_pkg::FULL_AW'(GRID_WIDTH)
              + hrug_pkg::FULL_AW'(col[hrug_pkg::RC_W-1:0]);
    cell_ok = !col[33] && !row[33]
           && (col[32:0] < 33'(GRID_WIDTH)) && (row[32:0] < 33'(GRID_HEIGHT))
           && (addr_full < hrug_pkg::FULL_AW'(hrug_pkg::STORE_DEPTH));
    ram_raddr = addr_full[hrug_pkg::STORE_AW-1:0];

    div_req.start = div_go_q;
    case (state_q)
      S_DIVSX: begin
        div_req.dividend = adx;
        div_req.divisor  = hrug_pkg::DVS_W'(steps_q) + 1'b1;
      end
      S_DIVSY: begin
        div_req.dividend = ady;
        div_req.divisor  = hrug_pkg::DVS_W'(steps_q) + 1'b1;
      end
      S_DIVCX: begin
        div_req.dividend = aox;
        div_req.divisor  = edge_eff;
      end
      S_DIVCY: begin
        div_req.dividend = aoy;
        div_req.divisor  = edge_eff;
      end
      default: begin
        div_req.dividend = big;
        div_req.divisor  = edge_eff;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      cor_go_q   <= 1'b0;
      div_go_q   <= 1'b0;
      m_vld_q    <= 1'b0;
      mul_idx_q  <= '0;
      rd_cnt_q   <= '0;
      step_i_q   <= '0;
      steps_q    <= '0;
      emit_inc_q <= 1'b0;
      inc_q      <= 1'b0;
    end else begin
      cor_go_q <= 1'b0;
      div_go_q <= 1'b0;
      if (m_vld_q && m_axis_tready_i) begin
        m_vld_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (!clear_busy) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer && (s_axis_tuser_i == hrug_pkg::CMD_RAY)) begin
            rx_q     <= $signed(s_axis_tdata_i[51:20]);
            ry_q     <= $signed(s_axis_tdata_i[83:52]);
            head_q   <= s_axis_tdata_i[99:84];
            mx_q     <= $signed(s_axis_tdata_i[131:100]);
            my_q     <= $signed(s_axis_tdata_i[163:132]);
            mang_q   <= s_axis_tdata_i[179:164];
            rng_q    <= s_axis_tdata_i[210:180];
            cor_go_q <= 1'b1;
            state_q  <= S_COR1;
          end
        end
        S_COR1: begin
          if (cor_rsp.done) begin
            cr_q     <= cor_rsp.cos;
            sr_q     <= cor_rsp.sin;
            cor_go_q <= 1'b1;
            state_q  <= S_COR2;
          end
        end
        S_COR2: begin
          if (cor_rsp.done) begin
            cs_q      <= cor_rsp.cos;
            ss_q      <= cor_rsp.sin;
            mul_idx_q <= '0;
            state_q   <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q    <= op_a * op_b;
          mul_idx_q <= mul_idx_q + 1'b1;
          case (mul_idx_q)
            3'd1: acc_a_q <= 66'(prod_q);
            3'd2: acc_a_q <= acc_a_q - 66'(prod_q);
            3'd3: acc_b_q <= 66'(prod_q);
            3'd4: acc_b_q <= acc_b_q + 66'(prod_q);
            3'd5: acc_c_q <= prod_q;
            3'd6: begin
              acc_d_q <= prod_q;
              state_q <= S_POSE;
            end
            default: ;
          endcase
        end
        S_POSE: begin
          sx_q    <= sx_d;
          sy_q    <= sy_d;
          state_q <= S_OBS;
        end
        S_OBS: begin
          ox_q    <= ox_d;
          oy_q    <= oy_d;
          state_q <= S_GEO;
        end
        S_GEO: begin
          dx_q    <= 33'(ox_q) - 33'(sx_q);
          dy_q    <= 33'(oy_q) - 33'(sy_q);
          inc_q   <= rng_q < max_rd_q;
          state_q <= S_DIST;
        end
        S_DIST: begin
          if (adx < 33'(edge_eff) && ady < 33'(edge_eff)) begin
            steps_q <= '0;
            if (inc_q) begin
              div_go_q <= 1'b1;
              state_q  <= S_DIVCX;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            div_go_q <= 1'b1;
            state_q  <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_rsp.done) begin
            steps_q  <= n_d - 1'b1;
            div_go_q <= 1'b1;
            state_q  <= S_DIVSX;
          end
        end
        S_DIVSX: begin
          if (div_rsp.done) begin
            stx_q    <= dx_q[32] ? -div_rsp.quot[31:0] : div_rsp.quot[31:0];
            div_go_q <= 1'b1;
            state_q  <= S_DIVSY;
          end
        end
        S_DIVSY: begin
          if (div_rsp.done) begin
            sty_q    <= dy_q[32] ? -div_rsp.quot[31:0] : div_rsp.quot[31:0];
            px_q     <= sx_q;
            py_q     <= sy_q;
            step_i_q <= '0;
            if (inc_q) begin
              div_go_q <= 1'b1;
              state_q  <= S_DIVCX;
            end else if (steps_q != '0) begin
              emit_inc_q <= 1'b0;
              state_q    <= S_EMIT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_DIVCX: begin
          if (div_rsp.done) begin
            cx_q     <= fq;
            div_go_q <= 1'b1;
            state_q  <= S_DIVCY;
          end
        end
        S_DIVCY: begin
          if (div_rsp.done) begin
            cy_q     <= fq;
            rd_cnt_q <= '0;
            sum_q    <= {4'b0, inc_amt_q, 1'b0};
            state_q  <= S_READ;
          end
        end
        S_READ: begin
          rd_vld_q <= cell_ok;
          rd_ctr_q <= (rd_cnt_q == 4'd4);
          rd_cnt_q <= rd_cnt_q + 1'b1;
          if (rd_cnt_q != 4'd0 && rd_vld_q) begin
            sum_q <= sum_q + (rd_ctr_q ? {4'b0, ram_rdata, 1'b0}
                                       : {5'b0, ram_rdata});
          end
          if (rd_cnt_q == 4'd9) begin
            emit_inc_q <= 1'b1;
            px_q       <= sx_q;
            py_q       <= sy_q;
            step_i_q   <= '0;
            state_q    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_vld_q <= 1'b1;
            if (emit_inc_q) begin
              m_x_q      <= ox_q;
              m_y_q      <= oy_q;
              m_amt_q    <= sum_q;
              m_last_q   <= (steps_q == '0);
              emit_inc_q <= 1'b0;
              if (steps_q == '0) begin
                state_q <= S_IDLE;
              end
            end else begin
              m_x_q    <= px_q;
              m_y_q    <= py_q;
              m_amt_q  <= -{4'b0, dec_amt_q, 1'b0};
              m_last_q <= dec_last;
              px_q     <= px_q + stx_q;
              py_q     <= py_q + sty_q;
              step_i_q <= step_i_q + 1'b1;
              if (dec_last) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {3'b000, m_amt_q, m_y_q, m_x_q};
  assign m_axis_tlast_o  = m_last_q;

  a_no_input_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_busy |-> !s_axis_tready_o)
    else $error("input ready during grid clear");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_vld_q)
    else $error("result register not loaded");

  a_steps_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (steps_q <= STEP_W'(MAX_STEPS - 1)))
    else $error("step count beyond limit");

  a_div_idle_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_last_ends_ray : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !emit_inc_q && dec_last) |=> (state_q == S_IDLE))
    else $error("ray did not end after last transfer");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HIMM ray update generator: grid writes and
// range rays are streamed in under several register settings and handshake
// loads, and every update transfer is checked against a software predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int  GRID_W     = 64;
  localparam int  GRID_H     = 64;
  localparam int  STEP_CAP   = 63;
  localparam int  SETTLE     = 400;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic        cmd;
    logic [11:0] idx;
    logic [7:0]  val;
    logic [31:0] rx, ry, mx, my;
    logic [15:0] head, mang;
    logic [30:0] rng;
  } ray_item_t;

  typedef struct {
    logic [31:0] x, y;
    logic [12:0] amt;
    logic        last;
  } update_t;

  class ray_update_tracker;
    logic [7:0]  grid[4096];
    logic [7:0]  inc_amt, dec_amt;
    logic [30:0] max_rd, edge_len;
    update_t     pending_updates[$];
    int          errors;
    longint      atan_q32[24] = '{536870912, 316933406, 167458907, 85004756,
      42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    function new();
      foreach (grid[i]) grid[i] = '0;
      inc_amt = 8'd3; dec_amt = 8'd1; max_rd = 31'd327680; edge_len = 31'd6554;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] a, logic [30:0] d);
      case (a)
        hrug_pkg::CFG_INC_AMT: inc_amt = d[7:0];
        hrug_pkg::CFG_DEC_AMT: dec_amt = d[7:0];
        hrug_pkg::CFG_MAX_RD:  max_rd = d;
        hrug_pkg::CFG_EDGE:    edge_len = d;
        default: ;
      endcase
    endfunction

    function void sincos(input logic [15:0] ang, output longint c, output longint s);
      longint x, y, z, xs, ys;
      x = 652032874; y = 0;
      z = longint'(ang[13:0]) << 16;
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_q32[i];
        end else begin
          x += ys; y -= xs; z += atan_q32[i];
        end
      end
      case (ang[15:14])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint rnd30(longint v);
      return (v + 64'sd536870912) >>> 30;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint cell_at(longint x, longint y, longint e);
      longint col, row, addr;
      if (x < 0 || y < 0) return 0;
      col = x / e; row = y / e;
      if (col >= GRID_W || row >= GRID_H) return 0;
      addr = row * GRID_W + col;
      if (addr >= 4096) return 0;
      return longint'(grid[addr]);
    endfunction

    function void push(longint x, longint y, longint amt);
      update_t u;
      u.x = x[31:0]; u.y = y[31:0]; u.amt = amt[12:0]; u.last = 1'b0;
      pending_updates.insert(pending_updates.size(), u);
    endfunction

    function void absorb_item(ray_item_t it);
      longint rx, ry, mx, my, rng, e, cr, sr, cs, ss, sx, sy, ox, oy;
      longint dx, dy, adx, ady, n, stx, sty, px, py, sum;
      int added;
      if (it.cmd == hrug_pkg::CMD_WRITE) begin
        grid[it.idx] = it.val;
        return;
      end
      rx = longint'(signed'(it.rx)); ry = longint'(signed'(it.ry));
      mx = longint'(signed'(it.mx)); my = longint'(signed'(it.my));
      rng = longint'(it.rng);
      e = (edge_len == 0) ? 1 : longint'(edge_len);
      sincos(it.head, cr, sr);
      sincos(it.head + it.mang, cs, ss);
      sx = clamp32(rx + rnd30(mx * cr - my * sr));
      sy = clamp32(ry + rnd30(mx * sr + my * cr));
      ox = clamp32(sx + rnd30(rng * cs));
      oy = clamp32(sy + rnd30(rng * ss));
      added = 0;
      if (rng < longint'(max_rd)) begin
        sum = 2 * longint'(inc_amt);
        for (int q = -1; q <= 1; q++)
          for (int p = -1; p <= 1; p++)
            sum += ((p == 0 && q == 0) ? 2 : 1) * cell_at(ox + e * p, oy + e * q, e);
        push(ox, oy, sum);
        added++;
      end
      dx = ox - sx; dy = oy - sy;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      if (adx >= e || ady >= e) begin
        n = (adx > ady ? adx : ady) / e;
        if (n > STEP_CAP) n = STEP_CAP;
        stx = dx / n; sty = dy / n;
        px = sx; py = sy;
        for (longint i = 0; i < n - 1; i++) begin
          push(px, py, -2 * longint'(dec_amt));
          added++;
          px += stx; py += sty;
        end
      end
      if (added > 0) pending_updates[$].last = 1'b1;
    endfunction

    function void check_update(logic [31:0] x, logic [31:0] y, logic [12:0] amt,
                               logic last);
      update_t u;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected update x=%h y=%h amt=%h last=%b", $time, x, y, amt, last);
        errors++;
        return;
      end
      u = pending_updates.pop_front();
      if (x !== u.x) begin
        $display("%0t: update_x expected %h actual %h", $time, u.x, x); errors++;
      end
      if (y !== u.y) begin
        $display("%0t: update_y expected %h actual %h", $time, u.y, y); errors++;
      end
      if (amt !== u.amt) begin
        $display("%0t: update_amount expected %h actual %h", $time, u.amt, amt); errors++;
      end
      if (last !== u.last) begin
        $display("%0t: tlast expected %b actual %b", $time, u.last, last); errors++;
      end
    endfunction
  endclass

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid_i, s_axis_tready_o, s_axis_tuser_i;
  logic [215:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o, m_axis_tready_i, m_axis_tlast_o;
  logic [79:0]  m_axis_tdata_o;
  logic         cfg_wr_en_i;
  logic [1:0]   cfg_addr_i;
  logic [30:0]  cfg_wdata_i;

  ray_update_tracker tracker = new();
  int     idle_pct = 0, stall_pct = 0, sent = 0;
  longint cycles = 0;

  himm_ray_update_generator_unit dut (.*);

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_update(m_axis_tdata_o[31:0], m_axis_tdata_o[63:32],
                           m_axis_tdata_o[76:64], m_axis_tlast_o);
  end

  task automatic send(ray_item_t it);
    case ((sent / 20) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 55; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 55; end
      default: begin idle_pct = 7; stall_pct = 7; end
    endcase
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= it.cmd;
    s_axis_tdata_i  <= {5'b0, it.rng, it.mang, it.my, it.mx, it.head, it.ry, it.rx,
                        it.val, it.idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.absorb_item(it);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending_updates.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] a, logic [30:0] d);
    cfg_wr_en_i <= 1'b1; cfg_addr_i <= a; cfg_wdata_i <= d;
    @(posedge clk_i);
    tracker.set_reg(a, d);
  endtask

  task automatic setup(logic [7:0] inc, logic [7:0] dec, logic [30:0] mx,
                       logic [30:0] e);
    drain();
    write_reg(hrug_pkg::CFG_INC_AMT, {23'b0, inc});
    write_reg(hrug_pkg::CFG_DEC_AMT, {23'b0, dec});
    write_reg(hrug_pkg::CFG_MAX_RD, mx);
    write_reg(hrug_pkg::CFG_EDGE, e);
    cfg_wr_en_i <= 1'b0;
  endtask

  function automatic ray_item_t cell_write(int idx, int val);
    ray_item_t it;
    it = '{default: '0};
    it.cmd = hrug_pkg::CMD_WRITE; it.idx = 12'(idx); it.val = 8'(val);
    it.rx = $urandom; it.rng = 31'($urandom);
    return it;
  endfunction

  function automatic ray_item_t ray(logic [31:0] x, logic [31:0] y, logic [15:0] h,
                                    logic [31:0] mx, logic [31:0] my, logic [15:0] ma,
                                    logic [30:0] r);
    ray_item_t it;
    it = '{default: '0};
    it.cmd = hrug_pkg::CMD_RAY; it.rx = x; it.ry = y; it.head = h;
    it.mx = mx; it.my = my; it.mang = ma; it.rng = r;
    it.idx = 12'($urandom); it.val = 8'($urandom);
    return it;
  endfunction

  function automatic ray_item_t random_item();
    longint e, span;
    logic [31:0] mx, my;
    e = (tracker.edge_len == 0) ? 1 : longint'(tracker.edge_len);
    span = 64 * e;
    if (span > 64'd2147483647) span = 64'd2147483647;
    case ($urandom_range(9))
      0, 1: return cell_write($urandom_range(4095),
                              ($urandom_range(3) == 0) ? 255 : $urandom_range(255));
      2: return ray($urandom, $urandom, 16'($urandom), $urandom, $urandom,
                    16'($urandom), 31'($urandom));
      default: begin
        mx = 32'(longint'($urandom_range(32'(2 * e))) - e);
        my = 32'(longint'($urandom_range(32'(2 * e))) - e);
        return ray($urandom_range(32'(span - 1)), $urandom_range(32'(span - 1)),
                   16'($urandom), mx, my, 16'($urandom),
                   (span * 11 / 10 > 64'd2147483647) ? 31'($urandom) :
                   31'($urandom_range(32'(span * 11 / 10))));
      end
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i <= 1'b0; s_axis_tuser_i <= 1'b0; s_axis_tdata_i <= '0;
    cfg_wr_en_i <= 1'b0; cfg_addr_i <= '0; cfg_wdata_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: store corners, compass headings, reading limits, saturation
    send(cell_write(0, 255));
    send(cell_write(4095, 255));
    send(cell_write(1, 128));
    send(cell_write(65, 7));
    send(ray(0, 0, 0, 0, 0, 0, 0));
    send(ray(9831, 9831, 16'h0000, 0, 0, 0, 131072));
    send(ray(9831, 9831, 16'h4000, 0, 0, 0, 131072));
    send(ray(9831, 9831, 16'h8000, 6554, 0, 0, 131072));
    send(ray(9831, 9831, 16'hC000, 0, 6554, 16'h4000, 131072));
    send(ray(9831, 9831, 16'hFFFF, 0, 0, 16'hFFFF, 327679));
    send(ray(9831, 9831, 16'h2000, 0, 0, 0, 327680));
    send(ray(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h2000, 32'h7FFFFFFF, 32'h7FFFFFFF,
             16'h1234, 31'h7FFFFFFF));
    send(ray(32'h80000000, 32'h80000000, 16'hA000, 32'h80000000, 32'h80000000,
             16'hFFFF, 31'h7FFFFFFF));
    send(ray(416179, 416179, 16'h0000, 0, 0, 0, 6553));
    send(ray(3000, 3000, 16'h1000, 0, 0, 0, 655360));
    send(ray(416179, 3000, 16'h5000, 32'hFFFF0000, 32'h00010000, 16'h3000, 20000));

    for (int k = 0; k < 70; k++) send(random_item());
    setup(8'd255, 8'd255, 31'h7FFFFFFF, 31'd6554);
    for (int k = 0; k < 70; k++) send(random_item());
    setup(8'd0, 8'd0, 31'd0, 31'd1);
    for (int k = 0; k < 60; k++) send(random_item());
    setup(8'd9, 8'd200, 31'd400000, 31'h7FFFFFFF);
    for (int k = 0; k < 60; k++) send(random_item());
    setup(8'd3, 8'd1, 31'd327680, 31'd0);
    for (int k = 0; k < 60; k++) send(random_item());
    setup(8'd128, 8'd2, 31'd262144, 31'd20000);
    for (int k = 0; k < 85; k++) send(random_item());

    drain();
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
